// ===== hw/rtl/aps_pkg.sv =====
// aps_pkg: shared types, opcodes and arithmetic helpers for the A* path search block.
// No dependencies.
package aps_pkg;

	localparam int NODE_COUNT_DEF = 64;
	localparam int MAX_DEGREE_DEF = 8;

	localparam logic [1:0] OP_NODE     = 2'd0;
	localparam logic [1:0] OP_NEIGHBOR = 2'd1;
	localparam logic [1:0] OP_SEARCH   = 2'd2;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [5:0]         node_index;
		logic [2:0]         slot_index;
		logic [5:0]         other_index;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic [3:0]         degree;
	} req_t;

	typedef struct packed {
		logic [5:0] path_node;
		logic       found;
		logic       last;
	} rsp_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} pos_t;

	typedef struct packed {
		logic accept;
		logic ld_goal;
		logic init;
		logic scan_clr;
		logic scan_step;
		logic pick;
		logic ld_q;
		logic nb_rd;
		logic nb_chk;
		logic nb_eval;
		logic nb_upd;
		logic slot_inc;
		logic walk_init;
		logic walk_step;
		logic em_load;
		logic em_next;
		logic none_load;
	} cmd_t;

	typedef struct packed {
		logic search;
		logic oob;
		logic scan_last;
		logic any_open;
		logic q_is_goal;
		logic slot_done;
		logic n_oob;
		logic goal_is_start;
		logic par_is_start;
		logic taken;
		logic last;
	} sts_t;

	function automatic logic [16:0] abs_diff(logic signed [15:0] a, logic signed [15:0] b);
		logic signed [16:0] d;
		d = 17'(a) - 17'(b);
		return d[16] ? 17'(-d) : 17'(d);
	endfunction

	function automatic logic [17:0] manhattan(pos_t a, pos_t b);
		return 18'(abs_diff(a.x, b.x)) + 18'(abs_diff(a.y, b.y)) + 18'(abs_diff(a.z, b.z));
	endfunction

	function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = 33'(a) + 33'(b);
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage

// ===== hw/rtl/a_star_graph_path_search_top.sv =====
// a_star_graph_path_search_top: A* search over a stored graph, Manhattan cost and heuristic.
// Depends on aps_pkg, aps_ctrl, aps_dp.
// Node and neighbor writes are done on acceptance. A search checks its indices, loads the goal
// position, seeds the start, then scans, picks and expands neighbors until the goal or an empty
// open set, walks parents back and emits the path. One item at a time; ready only while idle.
// Reset clears control, open/closed flags and degree valid bits at once; no clearing pass.
module a_star_graph_path_search_top import aps_pkg::*; #(
	parameter int NODE_COUNT = NODE_COUNT_DEF,
	parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	cmd_t cmd;
	sts_t sts;

	aps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	aps_dp #(
		.NODE_COUNT (NODE_COUNT),
		.MAX_DEGREE (MAX_DEGREE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp_ready (rsp_ready),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.cmd       (cmd),
		.sts       (sts)
	);

	a_no_accept_while_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready) else $error("item accepted while result pending");

	a_miss_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.found) |-> rsp.last) else $error("not-found result not last");

	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && req.opcode == OP_SEARCH) |=> !req_ready)
		else $error("ready after search accepted");

endmodule

// ===== hw/rtl/aps_ctrl.sv =====
// aps_ctrl: sequencer for loads, open-set scans, neighbor expansion, path walk and output.
// Depends on aps_pkg.
module aps_ctrl import aps_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [17:0] {
		S_IDLE      = 18'h00001,
		S_CHECK     = 18'h00002,
		S_LD_GOAL   = 18'h00004,
		S_INIT      = 18'h00008,
		S_SCAN      = 18'h00010,
		S_SCAN_TAIL = 18'h00020,
		S_PICK      = 18'h00040,
		S_LD_Q      = 18'h00080,
		S_NB        = 18'h00100,
		S_NB_CHK    = 18'h00200,
		S_NB_EVAL   = 18'h00400,
		S_NB_UPD    = 18'h00800,
		S_WALK_INIT = 18'h01000,
		S_WALK_RD   = 18'h02000,
		S_WALK      = 18'h04000,
		S_EM_RD     = 18'h08000,
		S_EM_WAIT   = 18'h10000,
		S_NONE      = 18'h20000
	} state_t;

	state_t state_q, state_d;
	logic   em_load_q;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					if (sts.search) state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = sts.oob ? S_NONE : S_LD_GOAL;
			end
			S_LD_GOAL: begin
				cmd.ld_goal = 1'b1;
				state_d = S_INIT;
			end
			S_INIT: begin
				cmd.init = 1'b1;
				cmd.scan_clr = 1'b1;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) state_d = S_SCAN_TAIL;
			end
			S_SCAN_TAIL: begin
				state_d = S_PICK;
			end
			S_PICK: begin
				if (!sts.any_open) begin
					state_d = S_NONE;
				end else begin
					cmd.pick = 1'b1;
					state_d = sts.q_is_goal ? S_WALK_INIT : S_LD_Q;
				end
			end
			S_LD_Q: begin
				cmd.ld_q = 1'b1;
				state_d = S_NB;
			end
			S_NB: begin
				if (sts.slot_done) begin
					cmd.scan_clr = 1'b1;
					state_d = S_SCAN;
				end else begin
					cmd.nb_rd = 1'b1;
					state_d = S_NB_CHK;
				end
			end
			S_NB_CHK: begin
				if (sts.n_oob) begin
					cmd.slot_inc = 1'b1;
					state_d = S_NB;
				end else begin
					cmd.nb_chk = 1'b1;
					state_d = S_NB_EVAL;
				end
			end
			S_NB_EVAL: begin
				cmd.nb_eval = 1'b1;
				state_d = S_NB_UPD;
			end
			S_NB_UPD: begin
				cmd.nb_upd = 1'b1;
				cmd.slot_inc = 1'b1;
				state_d = S_NB;
			end
			S_WALK_INIT: begin
				cmd.walk_init = 1'b1;
				state_d = sts.goal_is_start ? S_EM_RD : S_WALK_RD;
			end
			S_WALK_RD: begin
				state_d = S_WALK;
			end
			S_WALK: begin
				cmd.walk_step = 1'b1;
				state_d = sts.par_is_start ? S_EM_RD : S_WALK_RD;
			end
			S_EM_RD: begin
				state_d = S_EM_WAIT;
			end
			S_EM_WAIT: begin
				cmd.em_load = em_load_q;
				if (sts.taken) begin
					if (sts.last) begin
						state_d = S_IDLE;
					end else begin
						cmd.em_next = 1'b1;
						state_d = S_EM_RD;
					end
				end
			end
			S_NONE: begin
				cmd.none_load = 1'b1;
				state_d = S_EM_WAIT;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			em_load_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			em_load_q <= (state_q == S_EM_RD);
		end
	end

endmodule

// ===== hw/rtl/aps_dp.sv =====
// aps_dp: graph stores, search state, open-set minimum, cost arithmetic and output register.
// Depends on aps_pkg.
module aps_dp import aps_pkg::*; #(
	parameter int NODE_COUNT = NODE_COUNT_DEF,
	parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  logic rsp_ready,
	output logic rsp_valid,
	output rsp_t rsp,
	input  cmd_t cmd,
	output sts_t sts
);

	localparam int NW = $clog2(NODE_COUNT);
	localparam int DW = $clog2(MAX_DEGREE + 1);
	localparam int AW = $clog2(NODE_COUNT * MAX_DEGREE);

	pos_t            pos_mem [NODE_COUNT];
	logic [DW-1:0]   deg_mem [NODE_COUNT];
	logic [5:0]      nb_mem  [NODE_COUNT * MAX_DEGREE];
	logic [63:0]     cost_mem[NODE_COUNT];
	logic [NW-1:0]   par_mem [NODE_COUNT];
	logic [NW-1:0]   chain_mem[NODE_COUNT];

	logic [NODE_COUNT-1:0] deg_vld_q, open_q, closed_q;

	pos_t          pos_rd_q, goal_pos_q, q_pos_q;
	logic [DW-1:0] deg_rd_q, q_deg_q, slot_q;
	logic          dvld_rd_q;
	logic [5:0]    nb_rd_q, start_q, goal_q;
	logic [63:0]   cost_rd_q;
	logic [NW-1:0] par_rd_q, chain_rd_q;
	logic [NW-1:0] scan_i_q, scan_i_s1, best_q, n_q, cur_q, top_q;
	logic          scan_v_s1, any_q;
	logic [31:0]   best_f_q, best_g_q, g_new_q, h_new_q, fn_q;
	rsp_t          rsp_q;
	logic          rsp_valid_q;

	logic [NW-1:0] start_i, goal_i, n_i, pos_ra, cost_ra;
	logic [AW-1:0] nb_wa, nb_ra;
	logic          node_ok, slot_ok, wr_node, wr_nb, cost_we, skip;
	logic [63:0]   cost_wd;
	logic [NW-1:0] cost_wa;
	logic [31:0]   f_s1, f_new;
	logic [DW-1:0] deg_sat;
	logic          push;

	assign start_i = start_q[NW-1:0];
	assign goal_i  = goal_q[NW-1:0];
	assign n_i     = nb_rd_q[NW-1:0];

	assign node_ok = {1'b0, req.node_index} < 7'(NODE_COUNT);
	assign slot_ok = 32'(req.slot_index) < MAX_DEGREE;
	assign wr_node = cmd.accept && req.opcode == OP_NODE && node_ok;
	assign wr_nb   = cmd.accept && req.opcode == OP_NEIGHBOR && node_ok && slot_ok;
	assign deg_sat = (32'(req.degree) > MAX_DEGREE) ? DW'(MAX_DEGREE) : DW'(req.degree);
	assign nb_wa   = AW'(32'(req.node_index[NW-1:0]) * MAX_DEGREE + 32'(req.slot_index));
	assign nb_ra   = AW'(32'(best_q) * MAX_DEGREE + 32'(slot_q));

	always_comb begin
		pos_ra = goal_i;
		if (cmd.ld_goal) pos_ra = start_i;
		else if (cmd.pick) pos_ra = best_q;
		else if (cmd.nb_chk) pos_ra = n_i;
	end
	assign cost_ra = cmd.nb_chk ? n_i : scan_i_q;

	assign f_new = sat_add(g_new_q, h_new_q);
	assign skip  = (open_q[n_q] || closed_q[n_q]) && fn_q <= f_new;
	assign f_s1  = sat_add(cost_rd_q[63:32], cost_rd_q[31:0]);

	always_comb begin
		cost_we = 1'b0;
		cost_wa = n_q;
		cost_wd = {g_new_q, h_new_q};
		if (cmd.init) begin
			cost_we = 1'b1;
			cost_wa = start_i;
			cost_wd = {32'd0, 32'(manhattan(pos_rd_q, goal_pos_q))};
		end else if (cmd.nb_upd && !skip) begin
			cost_we = 1'b1;
		end
	end

	assign push = cmd.walk_step && par_rd_q != start_i && 32'(top_q) < NODE_COUNT - 1;

	// stores, read data registered
	always_ff @(posedge clk) begin
		if (wr_node) begin
			pos_mem[req.node_index[NW-1:0]] <= '{x: req.pos_x, y: req.pos_y, z: req.pos_z};
			deg_mem[req.node_index[NW-1:0]] <= deg_sat;
		end
		if (wr_nb) nb_mem[nb_wa] <= req.other_index;
		if (cost_we) cost_mem[cost_wa] <= cost_wd;
		if (cmd.nb_upd && !skip) par_mem[n_q] <= best_q;
		if (cmd.walk_init) chain_mem[top_q ^ top_q] <= goal_i;
		else if (push) chain_mem[top_q + 1'b1] <= par_rd_q;
		pos_rd_q   <= pos_mem[pos_ra];
		deg_rd_q   <= deg_mem[best_q];
		if (cmd.nb_rd) nb_rd_q <= nb_mem[nb_ra];
		cost_rd_q  <= cost_mem[cost_ra];
		par_rd_q   <= par_mem[cur_q];
		chain_rd_q <= chain_mem[top_q];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			start_q <= req.node_index;
			goal_q  <= req.other_index;
		end
		if (cmd.ld_goal) goal_pos_q <= pos_rd_q;
		if (cmd.ld_q) begin
			q_pos_q <= pos_rd_q;
			q_deg_q <= dvld_rd_q ? deg_rd_q : '0;
		end
		if (cmd.nb_chk) n_q <= n_i;
		if (cmd.nb_eval) begin
			g_new_q <= sat_add(best_g_q, 32'(manhattan(q_pos_q, pos_rd_q)));
			h_new_q <= 32'(manhattan(pos_rd_q, goal_pos_q));
			fn_q    <= sat_add(cost_rd_q[63:32], cost_rd_q[31:0]);
		end
		if (scan_v_s1 && open_q[scan_i_s1] && (!any_q || f_s1 < best_f_q)) begin
			best_f_q <= f_s1;
			best_g_q <= cost_rd_q[63:32];
			best_q   <= scan_i_s1;
		end
		scan_i_s1 <= scan_i_q;
		if (cmd.em_load) rsp_q <= '{path_node: 6'(chain_rd_q), found: 1'b1, last: top_q == '0};
		else if (cmd.none_load) rsp_q <= '{path_node: start_q, found: 1'b0, last: 1'b1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_vld_q   <= '0;
			open_q      <= '0;
			closed_q    <= '0;
			dvld_rd_q   <= 1'b0;
			scan_i_q    <= '0;
			scan_v_s1   <= 1'b0;
			any_q       <= 1'b0;
			slot_q      <= '0;
			cur_q       <= '0;
			top_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			dvld_rd_q <= deg_vld_q[best_q];
			if (wr_node) deg_vld_q[req.node_index[NW-1:0]] <= 1'b1;
			if (cmd.accept && req.opcode == OP_SEARCH) begin
				open_q   <= '0;
				closed_q <= '0;
			end
			if (cmd.init) open_q[start_i] <= 1'b1;
			if (cmd.pick) begin
				open_q[best_q]   <= 1'b0;
				closed_q[best_q] <= 1'b1;
			end
			if (cmd.nb_upd && !skip) begin
				open_q[n_q]   <= 1'b1;
				closed_q[n_q] <= 1'b0;
			end
			scan_v_s1 <= cmd.scan_step;
			if (cmd.scan_clr) begin
				scan_i_q <= '0;
				any_q    <= 1'b0;
			end else if (cmd.scan_step) begin
				scan_i_q <= scan_i_q + 1'b1;
			end
			if (scan_v_s1 && open_q[scan_i_s1]) any_q <= 1'b1;
			if (cmd.ld_q) slot_q <= '0;
			else if (cmd.slot_inc) slot_q <= slot_q + 1'b1;
			if (cmd.walk_init) begin
				cur_q <= goal_i;
				top_q <= '0;
			end else if (cmd.walk_step) begin
				cur_q <= par_rd_q;
				if (push) top_q <= top_q + 1'b1;
			end else if (cmd.em_next) begin
				top_q <= top_q - 1'b1;
			end
			if (cmd.em_load || cmd.none_load) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign sts.search        = req.opcode == OP_SEARCH;
	assign sts.oob           = {1'b0, start_q} >= 7'(NODE_COUNT) ||
	                           {1'b0, goal_q} >= 7'(NODE_COUNT);
	assign sts.scan_last     = 32'(scan_i_q) == NODE_COUNT - 1;
	assign sts.any_open      = any_q;
	assign sts.q_is_goal     = best_q == goal_i;
	assign sts.slot_done     = slot_q >= q_deg_q;
	assign sts.n_oob         = {1'b0, nb_rd_q} >= 7'(NODE_COUNT);
	assign sts.goal_is_start = goal_q == start_q;
	assign sts.par_is_start  = par_rd_q == start_i;
	assign sts.taken         = rsp_valid_q && rsp_ready;
	assign sts.last          = rsp_q.last;

endmodule
